// ----- rtl/ipv4f_pkg.sv -----
// Shared types and constants for the IPv4 receive header filter.
package ipv4f_pkg;

  localparam int LEN_W  = 16;
  localparam int ADDR_W = 32;
  localparam int ERR_W  = 32;

  localparam logic [LEN_W-1:0]  LEN_MAX     = 16'hFFFF;
  localparam logic [LEN_W-1:0]  MIN_FRAME   = 16'd20;
  localparam logic [5:0]        MIN_HDR     = 6'd20;
  localparam logic [3:0]        IP_VERSION  = 4'd4;
  localparam logic [15:0]       CSUM_OK     = 16'hFFFF;
  localparam logic [ADDR_W-1:0] BCAST_ADDR  = 32'hFFFF_FFFF;

  localparam logic [LEN_W-1:0] POS_VER_IHL = 16'd0;
  localparam logic [LEN_W-1:0] POS_TLEN_HI = 16'd2;
  localparam logic [LEN_W-1:0] POS_TLEN_LO = 16'd3;
  localparam logic [LEN_W-1:0] POS_PROTO   = 16'd9;
  localparam logic [LEN_W-1:0] POS_SRC     = 16'd12;
  localparam logic [LEN_W-1:0] POS_DST     = 16'd16;
  localparam logic [LEN_W-1:0] POS_HDR_END = 16'd20;

  localparam logic [7:0] PROTO_ICMP = 8'd1;
  localparam logic [7:0] PROTO_TCP  = 8'd6;
  localparam logic [7:0] PROTO_UDP  = 8'd17;

  typedef enum logic [2:0] {
    V_SHORT    = 3'd0,
    V_VERSION  = 3'd1,
    V_HDR_LEN  = 3'd2,
    V_CHECKSUM = 3'd3,
    V_NOT_ADDR = 3'd4,
    V_ACCEPT   = 3'd5
  } verdict_t;

  typedef enum logic [1:0] {
    PC_ICMP  = 2'd0,
    PC_UDP   = 2'd1,
    PC_TCP   = 2'd2,
    PC_OTHER = 2'd3
  } pclass_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] data_byte;
    logic       last_byte;
  } beat_t;

  typedef struct packed {
    verdict_t          verdict;
    pclass_t           protocol_class;
    logic [7:0]        protocol_number;
    logic [ADDR_W-1:0] source_address;
    logic [ADDR_W-1:0] destination_address;
    logic [5:0]        header_bytes;
    logic [LEN_W-1:0]  payload_length;
    logic [ERR_W-1:0]  errors_so_far;
  } result_t;

endpackage

// ----- rtl/ipv4f_if.sv -----
// Handshake channel interfaces: byte input, verdict output, configuration write.
interface ipv4f_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;
  modport source (output valid, data_byte, last_byte, input ready);
  modport sink (input valid, data_byte, last_byte, output ready);
endinterface

interface ipv4f_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  verdict;
  logic [1:0]  protocol_class;
  logic [7:0]  protocol_number;
  logic [31:0] source_address;
  logic [31:0] destination_address;
  logic [5:0]  header_bytes;
  logic [15:0] payload_length;
  logic [31:0] errors_so_far;
  modport source (output valid, verdict, protocol_class, protocol_number, source_address,
                  destination_address, header_bytes, payload_length, errors_so_far,
                  input ready);
  modport sink (input valid, verdict, protocol_class, protocol_number, source_address,
                destination_address, header_bytes, payload_length, errors_so_far,
                output ready);
endinterface

interface ipv4f_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] local_address;
  modport source (output valid, local_address, input ready);
  modport sink (input valid, local_address, output ready);
endinterface

// ----- rtl/ipv4f_in_reg.sv -----
// Input register: holds one byte beat until the header logic consumes it.
module ipv4f_in_reg (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            run,
  input  logic            adv,
  ipv4f_in_if.sink        in_bus,
  output ipv4f_pkg::beat_t s1
);
  import ipv4f_pkg::*;

  beat_t s1_r;
  logic  take;

  assign in_bus.ready = run && (!s1_r.valid || adv);
  assign take         = in_bus.valid && in_bus.ready;
  assign s1           = s1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r.valid <= 1'b0;
    end else if (take || adv) begin
      s1_r.valid <= take;
    end
    if (take) begin
      s1_r.data_byte <= in_bus.data_byte;
      s1_r.last_byte <= in_bus.last_byte;
    end
  end

endmodule

// ----- rtl/ipv4f_hdr_eval.sv -----
// Per-frame header state, checksum accumulation and verdict logic.
module ipv4f_hdr_eval #(
  parameter int ERROR_COUNT_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  ipv4f_pkg::beat_t             s1,
  input  logic                         adv,
  input  logic [ipv4f_pkg::ADDR_W-1:0] local_address,
  output ipv4f_pkg::result_t           res
);
  import ipv4f_pkg::*;

  logic [LEN_W-1:0]            byte_count_r, byte_count_nxt;
  logic [15:0]                 csum_r, csum_nxt;
  logic [7:0]                  hold_r, hold_nxt;
  logic [7:0]                  vl_r, vl_nxt;
  logic [15:0]                 tlen_r, tlen_nxt;
  logic [7:0]                  proto_r, proto_nxt;
  logic [ADDR_W-1:0]           src_r, src_nxt;
  logic [ADDR_W-1:0]           dst_r, dst_nxt;
  logic [ERROR_COUNT_BITS-1:0] err_r, err_nxt;

  logic [LEN_W-1:0] p;
  logic [7:0]       b;
  logic [5:0]       ihl;
  logic [16:0]      sum17;
  logic [LEN_W-1:0] clamp, avail;

  assign p = byte_count_r;
  assign b = s1.data_byte;

  always_comb begin
    vl_nxt    = (p == POS_VER_IHL) ? b : vl_r;
    ihl       = {vl_nxt[3:0], 2'b00};
    hold_nxt  = hold_r;
    csum_nxt  = csum_r;
    sum17     = {1'b0, csum_r} + {1'b0, hold_r, b};
    if (p < {10'd0, ihl}) begin
      if (!p[0]) begin
        hold_nxt = b;
      end else begin
        csum_nxt = sum17[15:0] + {15'd0, sum17[16]};
      end
    end
    tlen_nxt  = tlen_r;
    if (p == POS_TLEN_HI) tlen_nxt = {b, tlen_r[7:0]};
    if (p == POS_TLEN_LO) tlen_nxt = {tlen_r[15:8], b};
    proto_nxt = (p == POS_PROTO) ? b : proto_r;
    src_nxt   = (p >= POS_SRC && p < POS_DST) ? {src_r[ADDR_W-9:0], b} : src_r;
    dst_nxt   = (p >= POS_DST && p < POS_HDR_END) ? {dst_r[ADDR_W-9:0], b} : dst_r;
    byte_count_nxt = (p < LEN_MAX) ? p + 16'd1 : p;

    err_nxt   = err_r;
    clamp     = tlen_nxt - {10'd0, ihl};
    avail     = byte_count_nxt - {10'd0, ihl};

    res.protocol_class      = PC_ICMP;
    res.header_bytes        = '0;
    res.payload_length      = '0;
    res.protocol_number     = proto_nxt;
    res.source_address      = src_nxt;
    res.destination_address = dst_nxt;

    priority if (byte_count_nxt < MIN_FRAME) begin
      res.verdict = V_SHORT;
    end else if (vl_nxt[7:4] != IP_VERSION) begin
      res.verdict = V_VERSION;
    end else if (ihl < MIN_HDR || {10'd0, ihl} > byte_count_nxt) begin
      res.verdict = V_HDR_LEN;
    end else if (csum_nxt != CSUM_OK) begin
      res.verdict = V_CHECKSUM;
      err_nxt     = err_r + 1'b1;
    end else if (dst_nxt != local_address && dst_nxt != BCAST_ADDR) begin
      res.verdict = V_NOT_ADDR;
    end else begin
      res.verdict        = V_ACCEPT;
      res.header_bytes   = ihl;
      res.payload_length = (avail > clamp) ? clamp : avail;
      unique case (proto_nxt)
        PROTO_ICMP: res.protocol_class = PC_ICMP;
        PROTO_UDP:  res.protocol_class = PC_UDP;
        PROTO_TCP:  res.protocol_class = PC_TCP;
        default:    res.protocol_class = PC_OTHER;
      endcase
    end
    res.errors_so_far = ERR_W'(err_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r <= '0;
      csum_r       <= '0;
      hold_r       <= '0;
      vl_r         <= '0;
      tlen_r       <= '0;
      proto_r      <= '0;
      src_r        <= '0;
      dst_r        <= '0;
      err_r        <= '0;
    end else if (adv) begin
      if (s1.last_byte) begin
        byte_count_r <= '0;
        csum_r       <= '0;
        hold_r       <= '0;
        vl_r         <= '0;
        tlen_r       <= '0;
        proto_r      <= '0;
        src_r        <= '0;
        dst_r        <= '0;
        err_r        <= err_nxt;
      end else begin
        byte_count_r <= byte_count_nxt;
        csum_r       <= csum_nxt;
        hold_r       <= hold_nxt;
        vl_r         <= vl_nxt;
        tlen_r       <= tlen_nxt;
        proto_r      <= proto_nxt;
        src_r        <= src_nxt;
        dst_r        <= dst_nxt;
      end
    end
  end

endmodule

// ----- rtl/ipv4f_out_reg.sv -----
// Result register driving the verdict channel.
module ipv4f_out_reg (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  ipv4f_pkg::result_t   res,
  output logic                 free,
  ipv4f_out_if.source          out_bus
);
  import ipv4f_pkg::*;

  logic    out_valid_r;
  result_t res_r;

  assign free = !out_valid_r || out_bus.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (free) begin
      out_valid_r <= load;
    end
    if (load) begin
      res_r <= res;
    end
  end

  assign out_bus.valid               = out_valid_r;
  assign out_bus.verdict             = res_r.verdict;
  assign out_bus.protocol_class      = res_r.protocol_class;
  assign out_bus.protocol_number     = res_r.protocol_number;
  assign out_bus.source_address      = res_r.source_address;
  assign out_bus.destination_address = res_r.destination_address;
  assign out_bus.header_bytes        = res_r.header_bytes;
  assign out_bus.payload_length      = res_r.payload_length;
  assign out_bus.errors_so_far       = res_r.errors_so_far;

endmodule

// ----- rtl/ipv4_rx_header_filter_unit.sv -----
// Top level of the IPv4 receive header filter.
//
// in_bus takes one datagram byte per beat, starting at the first header byte;
// last_byte marks the final byte of a frame. Every frame yields exactly one
// beat on out_bus, carrying the verdict, header fields, payload length and the
// running checksum error count. cfg_bus writes local_address; write it only
// while no frame is in flight.
// Throughput: one byte per cycle, including back-to-back frames, while out_bus takes results.
// The last byte's beat passes the input register, then the header logic into
// the result register, which drives out_bus.
// Reset clears all frame state, the error counter and local_address; ready on
// both input channels stays low during reset.
// When out_bus stalls, the result register holds its beat; non-final bytes keep
// flowing, and a new final byte waits in the input register until the held
// result is taken, so in_bus ready drops only in that case.
module ipv4_rx_header_filter_unit #(
  parameter int ERROR_COUNT_BITS = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  ipv4f_in_if.sink     in_bus,
  ipv4f_out_if.source  out_bus,
  ipv4f_cfg_if.sink    cfg_bus
);
  import ipv4f_pkg::*;

  logic              run_r;
  logic [ADDR_W-1:0] local_address_r;
  beat_t             s1;
  result_t           res;
  logic              free;
  logic              adv;
  logic              load;

  assign adv            = s1.valid && (!s1.last_byte || free);
  assign load           = adv && s1.last_byte;
  assign cfg_bus.ready  = run_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r           <= 1'b0;
      local_address_r <= '0;
    end else begin
      run_r <= 1'b1;
      if (cfg_bus.valid && cfg_bus.ready) begin
        local_address_r <= cfg_bus.local_address;
      end
    end
  end

  ipv4f_in_reg u_in_reg (
    .clk    (clk),
    .rst_n  (rst_n),
    .run    (run_r),
    .adv    (adv),
    .in_bus (in_bus),
    .s1     (s1)
  );

  ipv4f_hdr_eval #(
    .ERROR_COUNT_BITS (ERROR_COUNT_BITS)
  ) u_hdr_eval (
    .clk           (clk),
    .rst_n         (rst_n),
    .s1            (s1),
    .adv           (adv),
    .local_address (local_address_r),
    .res           (res)
  );

  ipv4f_out_reg u_out_reg (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (load),
    .res     (res),
    .free    (free),
    .out_bus (out_bus)
  );

  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> out_bus.valid)
    else $error("final byte did not produce a result");

  a_stall_only_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (run_r && !in_bus.ready) |-> (s1.valid && s1.last_byte && out_bus.valid))
    else $error("input stalled without a held final byte");

  a_reject_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_bus.valid && out_bus.verdict != V_ACCEPT) |->
      (out_bus.header_bytes == 6'd0 && out_bus.payload_length == 16'd0))
    else $error("rejected frame carries header or payload length");

  a_err_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (load && $past(load) && res.verdict != V_CHECKSUM) |->
      (res.errors_so_far == $past(res.errors_so_far)))
    else $error("error count moved without a checksum failure");

endmodule
